// ===== sv/dqpd_pkg.sv =====
package dqpd_pkg;

  localparam int CNT_W  = 32;
  localparam int FRAC_W = 8;
  localparam int DVD_W  = CNT_W + FRAC_W;
  localparam int PPR_W  = 16;
  localparam int ANG_W  = 9;
  localparam int PROD_W = PPR_W + ANG_W;
  localparam int STEP_W = $clog2(DVD_W);
  localparam int LANES  = 2;

  localparam int LANE_L = 0;
  localparam int LANE_R = 1;

  localparam logic [PPR_W-1:0] PPR_RESET = PPR_W'(360);
  localparam logic [ANG_W-1:0] DEG_PER_REV = ANG_W'(360);

  typedef struct packed {
    logic [PPR_W-1:0] rem;
    logic             q;
  } dstep_t;

  // one restoring divide step: bring in one dividend bit, subtract if it fits
  function automatic dstep_t div_step(input logic [PPR_W-1:0] rem, input logic din,
                                      input logic [PPR_W-1:0] dvs);
    logic [PPR_W:0] t;
    dstep_t         r;
    t = {rem, din};
    if (t >= {1'b0, dvs}) begin
      r.rem = PPR_W'(t - {1'b0, dvs});
      r.q   = 1'b1;
    end else begin
      r.rem = t[PPR_W-1:0];
      r.q   = 1'b0;
    end
    return r;
  endfunction

endpackage

// ===== sv/dual_quadrature_position_decoder_core.sv =====
// channel | handshake            | word
// in      | in_valid / in_ready  | action, left/right pin a/b levels
// out     | out_valid / out_ready| left/right position, angle, turns_q8
// cfg     | cfg_valid / cfg_ready| pulses_per_rev (always ready)
//
// a result is loaded after these steps in order: a load step, 40 one-bit-per-cycle restoring
// divider steps for the turns, a registered multiply by 360, 9 more steps for the angle and
// the output load; the block then returns to idle before it takes the next word.
// reset (rst_n low, synchronous) clears counts and phases and sets pulses_per_rev to 360.
// a new word is taken while the last result still waits; a stalled output holds the
// block only at the final load.
module dual_quadrature_position_decoder_core (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_ready,
  input  logic                                 in_action,
  input  logic                                 in_left_pin_a,
  input  logic                                 in_left_pin_b,
  input  logic                                 in_right_pin_a,
  input  logic                                 in_right_pin_b,
  output logic                                 out_valid,
  input  logic                                 out_ready,
  output logic signed [dqpd_pkg::CNT_W-1:0]    out_left_position,
  output logic signed [dqpd_pkg::CNT_W-1:0]    out_right_position,
  output logic        [dqpd_pkg::ANG_W-1:0]    out_left_angle,
  output logic        [dqpd_pkg::ANG_W-1:0]    out_right_angle,
  output logic signed [dqpd_pkg::DVD_W-1:0]    out_left_turns_q8,
  output logic signed [dqpd_pkg::DVD_W-1:0]    out_right_turns_q8,
  input  logic                                 cfg_valid,
  output logic                                 cfg_ready,
  input  logic        [dqpd_pkg::PPR_W-1:0]    cfg_pulses_per_rev
);
  import dqpd_pkg::*;

  typedef enum logic [2:0] {S_IDLE, S_LOAD, S_DIV, S_MUL, S_ANG, S_DONE} state_t;

  state_t             st_r, st_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic [PPR_W-1:0]   ppr_r, ppr_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [1:0]         phase_r [LANES], phase_nxt [LANES];
  logic [CNT_W-1:0]   cnt_r [LANES], cnt_nxt [LANES];
  logic               neg_r [LANES], neg_nxt [LANES];
  logic [DVD_W-1:0]   dv_r [LANES], dv_nxt [LANES];
  logic [PPR_W-1:0]   rem_r [LANES], rem_nxt [LANES];
  logic [PPR_W-1:0]   rcap_r [LANES], rcap_nxt [LANES];
  logic [ANG_W-1:0]   ang_r [LANES], ang_nxt [LANES];
  logic [CNT_W-1:0]   opos_r [LANES], opos_nxt [LANES];
  logic [ANG_W-1:0]   oang_r [LANES], oang_nxt [LANES];
  logic [DVD_W-1:0]   oturn_r [LANES], oturn_nxt [LANES];

  logic               pin_a [LANES];
  logic               pin_b [LANES];
  logic [1:0]         now_ph [LANES];
  logic [1:0]         diff [LANES];
  logic [CNT_W-1:0]   mag [LANES];
  logic [PROD_W-1:0]  prod [LANES];
  dstep_t             ds [LANES];
  logic               in_acc;
  logic               out_free;

  assign pin_a[LANE_L] = in_left_pin_a;
  assign pin_b[LANE_L] = in_left_pin_b;
  assign pin_a[LANE_R] = in_right_pin_a;
  assign pin_b[LANE_R] = in_right_pin_b;

  assign in_ready  = (st_r == S_IDLE);
  assign in_acc    = in_valid && in_ready;
  assign out_free  = !out_valid_r || out_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    st_nxt        = st_r;
    step_nxt      = step_r;
    ppr_nxt       = ppr_r;
    out_valid_nxt = out_valid_r;
    if (cfg_valid) begin
      ppr_nxt = cfg_pulses_per_rev;
    end
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    for (int i = 0; i < LANES; i++) begin
      phase_nxt[i] = phase_r[i];
      cnt_nxt[i]   = cnt_r[i];
      neg_nxt[i]   = neg_r[i];
      dv_nxt[i]    = dv_r[i];
      rem_nxt[i]   = rem_r[i];
      rcap_nxt[i]  = rcap_r[i];
      ang_nxt[i]   = ang_r[i];
      opos_nxt[i]  = opos_r[i];
      oang_nxt[i]  = oang_r[i];
      oturn_nxt[i] = oturn_r[i];

      // gray to binary: 00,01,11,10 -> 0,1,2,3
      now_ph[i] = {pin_a[i], pin_a[i] ^ pin_b[i]};
      diff[i]   = phase_r[i] - now_ph[i];
      mag[i]    = cnt_r[i][CNT_W-1] ? CNT_W'(-cnt_r[i]) : cnt_r[i];
      prod[i]   = PROD_W'(rcap_r[i]) * PROD_W'(DEG_PER_REV);
      ds[i]     = div_step(rem_r[i], (st_r == S_ANG) ? ang_r[i][ANG_W-1] : dv_r[i][DVD_W-1],
                           ppr_r);
    end

    case (st_r)
      S_IDLE: begin
        if (in_acc) begin
          for (int i = 0; i < LANES; i++) begin
            if (in_action) begin
              phase_nxt[i] = now_ph[i];
              cnt_nxt[i]   = '0;
            end else if (diff[i][0]) begin
              phase_nxt[i] = now_ph[i];
              cnt_nxt[i]   = diff[i][1] ? cnt_r[i] + CNT_W'(1) : cnt_r[i] - CNT_W'(1);
            end
          end
          st_nxt = S_LOAD;
        end
      end
      S_LOAD: begin
        for (int i = 0; i < LANES; i++) begin
          neg_nxt[i] = cnt_r[i][CNT_W-1];
          dv_nxt[i]  = {mag[i], FRAC_W'(0)};
          rem_nxt[i] = '0;
        end
        step_nxt = '0;
        st_nxt   = S_DIV;
      end
      S_DIV: begin
        // dividend bits shift out the top, quotient bits shift in the bottom
        for (int i = 0; i < LANES; i++) begin
          dv_nxt[i]  = {dv_r[i][DVD_W-2:0], ds[i].q};
          rem_nxt[i] = ds[i].rem;
          if (step_r == STEP_W'(CNT_W - 1)) begin
            rcap_nxt[i] = ds[i].rem;
          end
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(DVD_W - 1)) begin
          st_nxt = S_MUL;
        end
      end
      S_MUL: begin
        // quotient fits in ANG_W bits, so the upper part is already below ppr
        for (int i = 0; i < LANES; i++) begin
          rem_nxt[i] = prod[i][PROD_W-1:ANG_W];
          ang_nxt[i] = prod[i][ANG_W-1:0];
        end
        step_nxt = '0;
        st_nxt   = S_ANG;
      end
      S_ANG: begin
        for (int i = 0; i < LANES; i++) begin
          ang_nxt[i] = {ang_r[i][ANG_W-2:0], ds[i].q};
          rem_nxt[i] = ds[i].rem;
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == STEP_W'(ANG_W - 1)) begin
          st_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (out_free) begin
          for (int i = 0; i < LANES; i++) begin
            opos_nxt[i] = cnt_r[i];
            if (ppr_r == '0) begin
              oang_nxt[i]  = '0;
              oturn_nxt[i] = '0;
            end else begin
              oang_nxt[i]  = ang_r[i];
              oturn_nxt[i] = neg_r[i] ? DVD_W'(-dv_r[i]) : dv_r[i];
            end
          end
          out_valid_nxt = 1'b1;
          st_nxt        = S_IDLE;
        end
      end
      default: begin
        st_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      step_r      <= '0;
      ppr_r       <= PPR_RESET;
      out_valid_r <= 1'b0;
      for (int i = 0; i < LANES; i++) begin
        phase_r[i] <= '0;
        cnt_r[i]   <= '0;
      end
    end else begin
      st_r        <= st_nxt;
      step_r      <= step_nxt;
      ppr_r       <= ppr_nxt;
      out_valid_r <= out_valid_nxt;
      for (int i = 0; i < LANES; i++) begin
        phase_r[i] <= phase_nxt[i];
        cnt_r[i]   <= cnt_nxt[i];
      end
    end
    for (int i = 0; i < LANES; i++) begin
      neg_r[i]   <= neg_nxt[i];
      dv_r[i]    <= dv_nxt[i];
      rem_r[i]   <= rem_nxt[i];
      rcap_r[i]  <= rcap_nxt[i];
      ang_r[i]   <= ang_nxt[i];
      opos_r[i]  <= opos_nxt[i];
      oang_r[i]  <= oang_nxt[i];
      oturn_r[i] <= oturn_nxt[i];
    end
  end

  assign out_valid          = out_valid_r;
  assign out_left_position  = opos_r[LANE_L];
  assign out_right_position = opos_r[LANE_R];
  assign out_left_angle     = oang_r[LANE_L];
  assign out_right_angle    = oang_r[LANE_R];
  assign out_left_turns_q8  = oturn_r[LANE_L];
  assign out_right_turns_q8 = oturn_r[LANE_R];

  a_accept_to_load: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> st_r == S_LOAD)
    else $error("accepted word did not start the divider");

  a_restart_clears: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc && in_action |=> cnt_r[LANE_L] == '0 && cnt_r[LANE_R] == '0)
    else $error("restart left a nonzero count");

  a_angle_range: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DONE && out_free |=> out_left_angle < DEG_PER_REV
                                   && out_right_angle < DEG_PER_REV)
    else $error("angle out of range");

  a_step_bound: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_ANG |-> step_r < STEP_W'(ANG_W))
    else $error("angle step counter overran");

  a_zero_ppr: assert property (@(posedge clk) disable iff (!rst_n)
    st_r == S_DONE && out_free && ppr_r == '0 |=> out_left_turns_q8 == '0
                                                  && out_right_turns_q8 == '0)
    else $error("zero pulses per rev gave nonzero turns");

endmodule
